[hw/rtl/fwtpl_pkg.sv]
package fwtpl_pkg;

    localparam int LANES = 4;

    // pi in Q16 and watts per 0.1 kW times 3000 (folds the 30 of rpm->rad/s)
    localparam logic [17:0] PI_Q16    = 18'd205887;
    localparam logic [18:0] W_PER_DKW = 19'd300000;

    localparam logic signed [15:0] TORQUE_MAX = 16'sh7FFF;
    localparam logic [10:0]        LIMIT_RESET = 11'd800;

    localparam int   ADDR_W          = 3;
    localparam logic REG_POWER_LIMIT = 1'b0;

    // dividend 2*num+den, divisor 2*den, quotient bits below saturation
    localparam int NUM_W = 62;
    localparam int DEN_W = 51;
    localparam int Q_W   = 15;

    typedef struct packed {
        logic signed [15:0] torque_fl;
        logic signed [15:0] torque_fr;
        logic signed [15:0] torque_rl;
        logic signed [15:0] torque_rr;
        logic signed [15:0] speed_fl;
        logic signed [15:0] speed_fr;
        logic signed [15:0] speed_rl;
        logic signed [15:0] speed_rr;
    } cmd_t;

    typedef struct packed {
        logic signed [15:0] limit_fl;
        logic signed [15:0] limit_fr;
        logic signed [15:0] limit_rl;
        logic signed [15:0] limit_rr;
        logic               limited;
    } res_t;

    typedef struct packed {
        logic                               limited;
        logic [LANES-1:0]                   zero;
        logic [LANES-1:0][NUM_W-1:0]        num;
        logic [LANES-1:0][DEN_W-1:0]        den;
        logic [LANES-1:0][15:0]             torque;
    } prep_t;

endpackage

[hw/rtl/fwtpl_if.sv]
interface fwtpl_cmd_if;
    logic                valid;
    logic                ready;
    fwtpl_pkg::cmd_t     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface fwtpl_res_if;
    logic                valid;
    logic                ready;
    fwtpl_pkg::res_t     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

[hw/rtl/four_wheel_torque_power_limiter_top.sv]
// Four-wheel torque power limiter.
// cmd (sink): four signed torque limits (0.01 Nm) and four signed wheel
// speeds (rpm) per item. res (source): four torque limits and a limited flag.
// Net power sum(|T|*rpm*pi/30) is checked against power_limit_decikw (APB
// register at byte address 0, 0.1 kW units, reset 800). Above the limit each
// corner becomes |T|/sum|T| * limit / |omega|, rounded, saturated to 32767;
// a stopped wheel gets 32767. Otherwise torques pass unchanged.
// Throughput: one item per cycle while the receiver takes results. Pipeline:
// 22 register stages: 5 multiply/compare stages, a saturation check,
// 15 restoring divide stages (one quotient bit each, four lanes in parallel)
// and the output register.
// A receiver stall holds the result in the output register; earlier stages
// keep filling bubbles, so cmd.ready drops only when all 22 stages are full.
// Reset empties the pipeline and loads the default power limit.
module four_wheel_torque_power_limiter_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [fwtpl_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    fwtpl_cmd_if.sink                     cmd,
    fwtpl_res_if.source                   res
);

    logic              [10:0] power_limit;
    logic                     mid_valid;
    logic                     mid_ready;
    fwtpl_pkg::prep_t         mid_data;

    fwtpl_cfg u_cfg (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .power_limit (power_limit)
    );

    fwtpl_prep u_prep (
        .clk         (clk),
        .rst_n       (rst_n),
        .power_limit (power_limit),
        .in_valid    (cmd.valid),
        .in_ready    (cmd.ready),
        .in_cmd      (cmd.payload),
        .out_valid   (mid_valid),
        .out_ready   (mid_ready),
        .out_data    (mid_data)
    );

    fwtpl_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mid_valid),
        .in_ready  (mid_ready),
        .in_data   (mid_data),
        .out_valid (res.valid),
        .out_ready (res.ready),
        .out_res   (res.payload)
    );

endmodule

[hw/rtl/fwtpl_cfg.sv]
module fwtpl_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [fwtpl_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    output logic [10:0]                   power_limit
);

    logic [10:0] limit_reg;
    logic [10:0] limit_next;
    logic        hit;

    assign hit = (paddr[2] == fwtpl_pkg::REG_POWER_LIMIT);

    always_comb
    begin
        limit_next = limit_reg;
        if (psel && penable && pwrite && hit)
        begin
            limit_next = pwdata[10:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= fwtpl_pkg::LIMIT_RESET;
        end
        else
        begin
            limit_reg <= limit_next;
        end
    end

    assign prdata      = hit ? {21'd0, limit_reg} : 32'd0;
    assign pready      = 1'b1;
    assign power_limit = limit_reg;

endmodule

[hw/rtl/fwtpl_prep.sv]
module fwtpl_prep (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [10:0]         power_limit,
    input  logic                in_valid,
    output logic                in_ready,
    input  fwtpl_pkg::cmd_t     in_cmd,
    output logic                out_valid,
    input  logic                out_ready,
    output fwtpl_pkg::prep_t    out_data
);

    localparam int N = fwtpl_pkg::LANES;

    function automatic logic [16:0] mag16(input logic signed [15:0] x);
        logic signed [16:0] xe;
        xe = 17'(x);
        return xe[16] ? 17'(-xe) : 17'(xe);
    endfunction

    logic [5:1] v_reg;
    logic [6:1] ld;

    logic signed [15:0] t_in [N];
    logic signed [15:0] s_in [N];

    // stage 1: magnitudes
    logic signed [15:0] t1_reg  [N];
    logic signed [15:0] s1_reg  [N];
    logic [16:0]        tm1_reg [N];
    logic [16:0]        sm1_reg [N];
    // stage 2: products with speed and limit, torque sum
    logic signed [15:0] t2_reg  [N];
    logic signed [31:0] pr2_reg [N];
    logic [27:0]        tl2_reg [N];
    logic [16:0]        sm2_reg [N];
    logic [17:0]        tsum2_reg;
    // stage 3: power sum, partial numerator and denominator
    logic signed [15:0] t3_reg   [N];
    logic [33:0]        den3_reg [N];
    logic [46:0]        num3_reg [N];
    logic [N-1:0]       zero3_reg;
    logic signed [33:0] ps3_reg;
    // stage 4: scale by pi
    logic signed [15:0] t4_reg   [N];
    logic [49:0]        den4_reg [N];
    logic [46:0]        num4_reg [N];
    logic [N-1:0]       zero4_reg;
    logic signed [52:0] lhs4_reg;
    logic [29:0]        rhs4_reg;
    // stage 5: compare, final dividend and divisor
    logic signed [15:0]                t5_reg   [N];
    logic [fwtpl_pkg::NUM_W-1:0]       num5_reg [N];
    logic [fwtpl_pkg::DEN_W-1:0]       den5_reg [N];
    logic [N-1:0]                      zero5_reg;
    logic                              lim5_reg;

    assign t_in[0] = in_cmd.torque_fl;
    assign t_in[1] = in_cmd.torque_fr;
    assign t_in[2] = in_cmd.torque_rl;
    assign t_in[3] = in_cmd.torque_rr;
    assign s_in[0] = in_cmd.speed_fl;
    assign s_in[1] = in_cmd.speed_fr;
    assign s_in[2] = in_cmd.speed_rl;
    assign s_in[3] = in_cmd.speed_rr;

    // a stage loads when empty or when everything after it moves
    always_comb
    begin
        ld[6] = out_ready;
        for (int k = 5; k >= 1; k--)
        begin
            ld[k] = !v_reg[k] || ld[k+1];
        end
    end

    assign in_ready  = ld[1];
    assign out_valid = v_reg[5];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (ld[1]) v_reg[1] <= in_valid;
            if (ld[2]) v_reg[2] <= v_reg[1];
            if (ld[3]) v_reg[3] <= v_reg[2];
            if (ld[4]) v_reg[4] <= v_reg[3];
            if (ld[5]) v_reg[5] <= v_reg[4];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld[1])
        begin
            for (int i = 0; i < N; i++)
            begin
                t1_reg[i]  <= t_in[i];
                s1_reg[i]  <= s_in[i];
                tm1_reg[i] <= mag16(t_in[i]);
                sm1_reg[i] <= mag16(s_in[i]);
            end
        end
        if (ld[2])
        begin
            for (int i = 0; i < N; i++)
            begin
                t2_reg[i]  <= t1_reg[i];
                pr2_reg[i] <= 32'($signed({1'b0, tm1_reg[i]}) * s1_reg[i]);
                tl2_reg[i] <= tm1_reg[i] * power_limit;
                sm2_reg[i] <= sm1_reg[i];
            end
            tsum2_reg <= 18'(tm1_reg[0]) + 18'(tm1_reg[1])
                       + 18'(tm1_reg[2]) + 18'(tm1_reg[3]);
        end
        if (ld[3])
        begin
            for (int i = 0; i < N; i++)
            begin
                t3_reg[i]    <= t2_reg[i];
                den3_reg[i]  <= 34'(tsum2_reg * sm2_reg[i]);
                num3_reg[i]  <= 47'(tl2_reg[i] * fwtpl_pkg::W_PER_DKW);
                zero3_reg[i] <= (sm2_reg[i] == 17'd0) || (tsum2_reg == 18'd0);
            end
            ps3_reg <= 34'(pr2_reg[0]) + 34'(pr2_reg[1])
                     + 34'(pr2_reg[2]) + 34'(pr2_reg[3]);
        end
        if (ld[4])
        begin
            for (int i = 0; i < N; i++)
            begin
                t4_reg[i]   <= t3_reg[i];
                den4_reg[i] <= 50'(den3_reg[i] * fwtpl_pkg::PI_Q16);
                num4_reg[i] <= num3_reg[i];
            end
            zero4_reg <= zero3_reg;
            lhs4_reg  <= 53'(ps3_reg * $signed({1'b0, fwtpl_pkg::PI_Q16}));
            rhs4_reg  <= power_limit * fwtpl_pkg::W_PER_DKW;
        end
        if (ld[5])
        begin
            for (int i = 0; i < N; i++)
            begin
                t5_reg[i]   <= t4_reg[i];
                // round to nearest: (2*num + den) / (2*den)
                num5_reg[i] <= fwtpl_pkg::NUM_W'({num4_reg[i], 17'd0})
                             + fwtpl_pkg::NUM_W'(den4_reg[i]);
                den5_reg[i] <= {den4_reg[i], 1'b0};
            end
            zero5_reg <= zero4_reg;
            lim5_reg  <= lhs4_reg > $signed({7'd0, rhs4_reg, 16'd0});
        end
    end

    always_comb
    begin
        out_data.limited = lim5_reg;
        out_data.zero    = zero5_reg;
        for (int i = 0; i < N; i++)
        begin
            out_data.num[i]    = num5_reg[i];
            out_data.den[i]    = den5_reg[i];
            out_data.torque[i] = t5_reg[i];
        end
    end

endmodule

[hw/rtl/fwtpl_div.sv]
module fwtpl_div (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  fwtpl_pkg::prep_t    in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output fwtpl_pkg::res_t     out_res
);

    localparam int N    = fwtpl_pkg::LANES;
    localparam int QW   = fwtpl_pkg::Q_W;
    localparam int NW   = fwtpl_pkg::NUM_W;
    localparam int DW   = fwtpl_pkg::DEN_W;
    localparam int CW   = DW + QW;
    localparam int N_ST = QW + 2;

    logic [N_ST-1:0] v_reg;
    logic [N_ST:0]   ld;

    // index 0 is the saturation check, 1..QW one quotient bit each
    logic [NW-1:0]      r_reg   [0:QW][N];
    logic [DW-1:0]      d_reg   [0:QW][N];
    logic [QW-1:0]      q_reg   [0:QW][N];
    logic [N-1:0]       sat_reg [0:QW];
    logic               lim_reg [0:QW];
    logic signed [15:0] t_reg   [0:QW][N];

    logic signed [15:0] res_reg [N];
    logic               res_lim_reg;

    always_comb
    begin
        ld[N_ST] = out_ready;
        for (int k = N_ST - 1; k >= 0; k--)
        begin
            ld[k] = !v_reg[k] || ld[k+1];
        end
    end

    assign in_ready  = ld[0];
    assign out_valid = v_reg[N_ST-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (ld[0]) v_reg[0] <= in_valid;
            for (int k = 1; k < N_ST; k++)
            begin
                if (ld[k]) v_reg[k] <= v_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld[0])
        begin
            for (int i = 0; i < N; i++)
            begin
                r_reg[0][i]   <= in_data.num[i];
                d_reg[0][i]   <= in_data.den[i];
                q_reg[0][i]   <= '0;
                t_reg[0][i]   <= in_data.torque[i];
                // quotient would not fit below the torque maximum
                sat_reg[0][i] <= in_data.zero[i]
                               || (CW'(in_data.num[i]) >= {in_data.den[i], QW'(0)});
            end
            lim_reg[0] <= in_data.limited;
        end
    end

    for (genvar k = 1; k <= QW; k++)
    begin : g_step
        localparam int B = QW - k;
        logic [CW-1:0] dsh [N];
        logic          ge  [N];

        always_comb
        begin
            for (int i = 0; i < N; i++)
            begin
                dsh[i] = CW'(d_reg[k-1][i]) << B;
                ge[i]  = CW'(r_reg[k-1][i]) >= dsh[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (ld[k])
            begin
                for (int i = 0; i < N; i++)
                begin
                    r_reg[k][i] <= ge[i] ? NW'(CW'(r_reg[k-1][i]) - dsh[i])
                                         : r_reg[k-1][i];
                    q_reg[k][i] <= q_reg[k-1][i] | (QW'(ge[i]) << B);
                    d_reg[k][i] <= d_reg[k-1][i];
                    t_reg[k][i] <= t_reg[k-1][i];
                end
                sat_reg[k] <= sat_reg[k-1];
                lim_reg[k] <= lim_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld[N_ST-1])
        begin
            for (int i = 0; i < N; i++)
            begin
                if (!lim_reg[QW])
                begin
                    res_reg[i] <= t_reg[QW][i];
                end
                else if (sat_reg[QW][i])
                begin
                    res_reg[i] <= fwtpl_pkg::TORQUE_MAX;
                end
                else
                begin
                    res_reg[i] <= {1'b0, q_reg[QW][i]};
                end
            end
            res_lim_reg <= lim_reg[QW];
        end
    end

    assign out_res.limit_fl = res_reg[0];
    assign out_res.limit_fr = res_reg[1];
    assign out_res.limit_rl = res_reg[2];
    assign out_res.limit_rr = res_reg[3];
    assign out_res.limited  = res_lim_reg;

endmodule

[hw/rtl/fwtpl_chk.sv]
module fwtpl_chk (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          psel,
    input logic                          penable,
    input logic                          pwrite,
    input logic [fwtpl_pkg::ADDR_W-1:0]  paddr,
    input logic [31:0]                   pwdata,
    input logic [31:0]                   prdata,
    input logic                          pready,
    input logic                          cmd_ready,
    input logic                          res_valid,
    input logic                          res_ready,
    input fwtpl_pkg::res_t               res_payload
);

    // held result stays put while the receiver stalls
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_payload))
        else $error("result changed under stall");

    // the pipeline only backs up from the output side
    a_no_self_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd_ready |-> res_valid && !res_ready)
        else $error("input stalled without output stall");

    // rescaled torques are magnitudes
    a_lim_positive: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_payload.limited |->
            !res_payload.limit_fl[15] && !res_payload.limit_fr[15]
            && !res_payload.limit_rl[15] && !res_payload.limit_rr[15])
        else $error("negative torque while limited");

    // register readback follows the last write
    a_cfg_readback: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && pready && (paddr[2] == fwtpl_pkg::REG_POWER_LIMIT)
        |=> (paddr[2] != fwtpl_pkg::REG_POWER_LIMIT) || (prdata[10:0] == $past(pwdata[10:0])))
        else $error("power limit readback mismatch");

endmodule

bind four_wheel_torque_power_limiter_top fwtpl_chk u_fwtpl_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .cmd_ready   (cmd.ready),
    .res_valid   (res.valid),
    .res_ready   (res.ready),
    .res_payload (res.payload)
);
